// ===== sv/hfd_pkg.sv =====
`default_nettype none

package hfd_pkg;

  localparam int unsigned UNIQUE_ADDR_BYTES = 5;
  localparam int unsigned ADDR_W = 40;
  localparam logic [7:0] UNIQUE_ADDR_CNT = 8'(UNIQUE_ADDR_BYTES);

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_ADDR  = 3'd1,
    PH_EXP   = 3'd2,
    PH_CMD   = 3'd3,
    PH_LEN   = 3'd4,
    PH_DATA  = 3'd5,
    PH_CHECK = 3'd6
  } phase_e;

  typedef enum logic {
    KIND_DATA    = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e              result_kind;
    logic [7:0]         payload_byte;
    logic [7:0]         payload_index;
    logic [ADDR_W-1:0]  device_address;
    logic               address_is_unique;
    logic [1:0]         expansion_count;
    logic [1:0]         physical_layer;
    logic [2:0]         frame_type;
    logic [7:0]         command_number;
    logic [7:0]         data_length;
    logic               check_ok;
    logic               last;
  } hfd_result_t;

  typedef struct packed {
    logic [1:0]  n;
    hfd_result_t r0;
    hfd_result_t r1;
  } hfd_push_t;

endpackage

`default_nettype wire

// ===== sv/hfd_parser.sv =====
`default_nettype none

module hfd_parser (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire logic [7:0]        rx_byte_i,
  input  wire logic              frame_start_i,
  input  wire logic              nested_frame_i,
  output hfd_pkg::hfd_push_t     push_o
);
  import hfd_pkg::*;

  phase_e            phase_q, phase_d;
  logic [7:0]        cnt_q, cnt_d;
  logic [7:0]        xor_q, xor_d;
  logic [7:0]        delim_q, delim_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [7:0]        cmd_q, cmd_d;
  logic [7:0]        len_q, len_d;
  logic              nested_q, nested_d;
  logic [7:0]        cnt_inc;
  logic [7:0]        addr_n;
  logic [1:0]        exp_n;
  hfd_push_t         push;

  function automatic hfd_result_t make_summary(
    input logic [7:0]        delim,
    input logic [ADDR_W-1:0] addr,
    input logic [7:0]        cmd,
    input logic [7:0]        len,
    input logic              ok
  );
    hfd_result_t r;
    r                   = '0;
    r.result_kind       = KIND_SUMMARY;
    r.device_address    = addr;
    r.address_is_unique = delim[7];
    r.expansion_count   = delim[6:5];
    r.physical_layer    = delim[4:3];
    r.frame_type        = delim[2:0];
    r.command_number    = cmd;
    r.data_length       = len;
    r.check_ok          = ok;
    r.last              = 1'b1;
    return r;
  endfunction

  function automatic hfd_result_t make_data(input logic [7:0] b, input logic [7:0] idx);
    hfd_result_t r;
    r               = '0;
    r.result_kind   = KIND_DATA;
    r.payload_byte  = b;
    r.payload_index = idx;
    r.last          = 1'b1;
    return r;
  endfunction

  assign cnt_inc = cnt_q + 8'd1;
  assign addr_n  = delim_q[7] ? UNIQUE_ADDR_CNT : 8'd1;
  assign exp_n   = delim_q[6:5];

  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    xor_d    = xor_q;
    delim_d  = delim_q;
    addr_d   = addr_q;
    cmd_d    = cmd_q;
    len_d    = len_q;
    nested_d = nested_q;
    push     = '0;
    if (frame_start_i) begin
      delim_d  = rx_byte_i;
      xor_d    = rx_byte_i;
      nested_d = nested_frame_i;
      addr_d   = '0;
      cmd_d    = '0;
      len_d    = '0;
      cnt_d    = '0;
      phase_d  = PH_ADDR;
    end else begin
      unique case (phase_q)
        PH_ADDR: begin
          xor_d  = xor_q ^ rx_byte_i;
          addr_d = {addr_q[ADDR_W-9:0], rx_byte_i};
          cnt_d  = cnt_inc;
          if (cnt_inc >= addr_n) begin
            cnt_d   = '0;
            phase_d = (exp_n != 2'd0) ? PH_EXP : PH_CMD;
          end
        end
        PH_EXP: begin
          xor_d = xor_q ^ rx_byte_i;
          cnt_d = cnt_inc;
          if (cnt_inc >= {6'd0, exp_n}) begin
            cnt_d   = '0;
            phase_d = PH_CMD;
          end
        end
        PH_CMD: begin
          xor_d   = xor_q ^ rx_byte_i;
          cmd_d   = rx_byte_i;
          phase_d = PH_LEN;
        end
        PH_LEN: begin
          xor_d = xor_q ^ rx_byte_i;
          len_d = rx_byte_i;
          cnt_d = '0;
          if (rx_byte_i != 8'd0) begin
            phase_d = PH_DATA;
          end else if (nested_q) begin
            phase_d = PH_IDLE;
            push.n  = 2'd1;
            push.r0 = make_summary(delim_q, addr_q, cmd_q, 8'd0, 1'b1);
          end else begin
            phase_d = PH_CHECK;
          end
        end
        PH_DATA: begin
          xor_d   = xor_q ^ rx_byte_i;
          push.n  = 2'd1;
          push.r0 = make_data(rx_byte_i, cnt_q);
          cnt_d   = cnt_inc;
          if (cnt_inc >= len_q) begin
            cnt_d = '0;
            if (nested_q) begin
              phase_d      = PH_IDLE;
              push.n       = 2'd2;
              push.r0.last = 1'b0;
              push.r1      = make_summary(delim_q, addr_q, cmd_q, len_q, 1'b1);
            end else begin
              phase_d = PH_CHECK;
            end
          end
        end
        PH_CHECK: begin
          phase_d = PH_IDLE;
          push.n  = 2'd1;
          push.r0 = make_summary(delim_q, addr_q, cmd_q, len_q, rx_byte_i == xor_q);
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end
    if (!accept_i) begin
      push.n = 2'd0;
    end
  end

  assign push_o = push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      cnt_q    <= '0;
      xor_q    <= '0;
      delim_q  <= '0;
      addr_q   <= '0;
      cmd_q    <= '0;
      len_q    <= '0;
      nested_q <= 1'b0;
    end else if (accept_i) begin
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      xor_q    <= xor_d;
      delim_q  <= delim_d;
      addr_q   <= addr_d;
      cmd_q    <= cmd_d;
      len_q    <= len_d;
      nested_q <= nested_d;
    end
  end

  // two results only at the end of a nested frame: data byte then summary
  a_two_results: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.n == 2'd2 |-> (!push.r0.last && push.r1.last &&
                        push.r0.result_kind == KIND_DATA &&
                        push.r1.result_kind == KIND_SUMMARY))
    else $error("two-result push malformed");

  a_no_push_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_IDLE && !frame_start_i) |-> push.n == 2'd0)
    else $error("result produced while idle");

endmodule

`default_nettype wire

// ===== sv/hfd_out_queue.sv =====
`default_nettype none

module hfd_out_queue (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire hfd_pkg::hfd_push_t   push_i,
  output logic                      full_o,
  output logic                      valid_o,
  input  wire logic                 stall_i,
  output hfd_pkg::hfd_result_t      head_o
);
  import hfd_pkg::*;

  hfd_result_t       entries_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic [QPTR_W-1:0] wr_nxt;
  logic              pop;

  assign pop     = valid_o && !stall_i;
  assign wr_nxt  = wr_ptr_q + QPTR_W'(1);
  assign valid_o = count_q != '0;
  assign full_o  = count_q > QCNT_W'(QUEUE_DEPTH - 2);
  assign head_o  = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q + QPTR_W'(push_i.n);
    rd_ptr_d = rd_ptr_q + QPTR_W'(pop);
    count_d  = count_q + QCNT_W'(push_i.n) - QCNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) begin
      entries_q[wr_ptr_q] <= push_i.r0;
    end
    if (push_i.n == 2'd2) begin
      entries_q[wr_nxt] <= push_i.r1;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (QCNT_W+1)'(count_q) + (QCNT_W+1)'(push_i.n) <= (QCNT_W+1)'(QUEUE_DEPTH))
    else $error("result queue overflow");

  a_push_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.n != 2'd3)
    else $error("push count out of range");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && push_i.n == 2'd0) |=> count_q == $past(count_q) - QCNT_W'(1))
    else $error("queue count did not drop on transaction");

endmodule

`default_nettype wire

// ===== sv/hart_frame_deframer.sv =====
// channel | valid      | stall       | payload
// in      | in_valid_i | in_stall_o  | rx_byte_i, frame_start_i, nested_frame_i
// out     | out_valid_o| out_stall_i | result_kind_o ... last_o (one result)
//
// one byte per cycle while in_stall_o is low; each result is registered in the queue before it shows
// a byte gives zero, one or two results; results wait in a four-entry queue
// in_stall_o rises while the queue has fewer than two free entries
// rst_ni clears the parser to idle and empties the queue
`default_nettype none

module hart_frame_deframer (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic [7:0]               rx_byte_i,
  input  wire logic                     frame_start_i,
  input  wire logic                     nested_frame_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic                          result_kind_o,
  output logic [7:0]                    payload_byte_o,
  output logic [7:0]                    payload_index_o,
  output logic [hfd_pkg::ADDR_W-1:0]    device_address_o,
  output logic                          address_is_unique_o,
  output logic [1:0]                    expansion_count_o,
  output logic [1:0]                    physical_layer_o,
  output logic [2:0]                    frame_type_o,
  output logic [7:0]                    command_number_o,
  output logic [7:0]                    data_length_o,
  output logic                          check_ok_o,
  output logic                          last_o
);
  import hfd_pkg::*;

  logic        accept;
  logic        full;
  hfd_push_t   push;
  hfd_result_t head;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  hfd_parser u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .rx_byte_i      (rx_byte_i),
    .frame_start_i  (frame_start_i),
    .nested_frame_i (nested_frame_i),
    .push_o         (push)
  );

  hfd_out_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (full),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .head_o  (head)
  );

  assign result_kind_o       = head.result_kind;
  assign payload_byte_o      = head.payload_byte;
  assign payload_index_o     = head.payload_index;
  assign device_address_o    = head.device_address;
  assign address_is_unique_o = head.address_is_unique;
  assign expansion_count_o   = head.expansion_count;
  assign physical_layer_o    = head.physical_layer;
  assign frame_type_o        = head.frame_type;
  assign command_number_o    = head.command_number;
  assign data_length_o       = head.data_length;
  assign check_ok_o          = head.check_ok;
  assign last_o              = head.last;

endmodule

`default_nettype wire
